// ----- rtl/fpa_pkg.sv -----
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and codes for the free partition allocator.
// ----------------------------------------------------------------------------
package fpa_pkg;

	localparam int unsigned FIELD_W = 16;

	typedef enum logic [1:0] {
		MODE_ALLOC   = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_APPEND  = 2'd2,
		MODE_NONE    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NOFIT = 2'd1,
		ST_FULL  = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	localparam logic CFG_POLICY    = 1'b0;
	localparam logic CFG_MIN_SPLIT = 1'b1;

	typedef struct packed {
		logic [1:0]         mode;
		logic [FIELD_W-1:0] block_base;
		logic [FIELD_W-1:0] block_length;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [FIELD_W-1:0] granted_base;
		logic [FIELD_W-1:0] granted_length;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_APPLY,
		S_SHIFT,
		S_DONE
	} fsm_t;

	// Shift command for the cell row.
	typedef enum logic [1:0] {
		SH_HOLD,
		SH_UP,
		SH_DOWN
	} shift_t;

endpackage

// ----- rtl/fpa_cell.sv -----
// ----------------------------------------------------------------------------
// fpa_cell
// One table entry: holds base and length, loads from the write port or from a neighbor on a shift.
// ----------------------------------------------------------------------------
module fpa_cell #(
	parameter int unsigned AW = 16
) (
	input  logic                 clk,
	input  fpa_pkg::shift_t      shift,
	input  logic                 shift_en,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_base,
	input  logic [AW-1:0]        wr_length,
	input  logic [AW-1:0]        below_base,
	input  logic [AW-1:0]        below_length,
	input  logic [AW-1:0]        above_base,
	input  logic [AW-1:0]        above_length,
	output logic [AW-1:0]        base,
	output logic [AW-1:0]        length
);

	logic [AW-1:0] base_q;
	logic [AW-1:0] length_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			base_q   <= wr_base;
			length_q <= wr_length;
		end else if (shift_en && shift == fpa_pkg::SH_UP) begin
			base_q   <= below_base;
			length_q <= below_length;
		end else if (shift_en && shift == fpa_pkg::SH_DOWN) begin
			base_q   <= above_base;
			length_q <= above_length;
		end
	end

	assign base   = base_q;
	assign length = length_q;

endmodule

// ----- rtl/free_partition_allocator.sv -----
// ----------------------------------------------------------------------------
// free_partition_allocator
// Address-ordered free partition table with next-fit / best-fit allocation,
// carving, whole grant, coalescing release and append.
// ----------------------------------------------------------------------------
//  port     | dir | handshake              | payload
//  in_*     | in  | in_valid / in_ready    | fpa_pkg::in_item_t
//  out_*    | out | out_valid / out_ready  | fpa_pkg::out_item_t
//  cfg_*    | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item at a time. After the accepting edge the scan pointer visits one live
// cell a cycle, then the apply state commits the in-place update, the shift
// state moves the cells one at a time toward the end of the shift span, and
// the done state raises the result. Every mode, append included, walks the
// full scan before its result shows.
// The row of cells has no reset; entry_count and rover clear at reset.
// A result waits in the output register; the next item is taken only after
// it leaves.
// ----------------------------------------------------------------------------
module free_partition_allocator #(
	parameter int unsigned ENTRIES   = 16,
	parameter int unsigned ADDR_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  fpa_pkg::in_item_t     in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output fpa_pkg::out_item_t    out_item,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [15:0]           cfg_data
);

	localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CW = $clog2(ENTRIES + 1);
	localparam int unsigned AW = ADDR_BITS;
	localparam logic [AW-1:0] AMAX = {AW{1'b1}};

	// configuration
	logic          policy_q;
	logic [15:0]   min_split_q;

	// control
	fpa_pkg::fsm_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic [IW-1:0] rover_q;
	logic [CW-1:0] n_q;        // scan step counter
	logic [IW-1:0] idx_q;      // current scan cell
	logic [1:0]    mode_q;
	logic [AW-1:0] req_base_q, req_len_q;
	logic          found_q, has_lo_q, has_up_q, has_pos_q;
	logic [IW-1:0] pick_q, lo_q, up_q, pos_q;
	logic [AW-1:0] pick_len_q;
	logic [IW-1:0] sh_idx_q, sh_end_q;
	fpa_pkg::shift_t sh_dir_q;
	fpa_pkg::out_item_t out_q;
	logic          out_valid_q;

	// cell row
	logic [AW-1:0] cb [ENTRIES];
	logic [AW-1:0] cl [ENTRIES];
	logic [ENTRIES-1:0] wr_en;
	logic [ENTRIES-1:0] sh_en;
	logic [AW-1:0] wr_base, wr_len;

	genvar g;
	generate
		for (g = 0; g < ENTRIES; g++) begin : g_cell
			fpa_cell #(.AW(AW)) u_cell (
				.clk         (clk),
				.shift       (sh_dir_q),
				.shift_en    (sh_en[g]),
				.wr_en       (wr_en[g]),
				.wr_base     (wr_base),
				.wr_length   (wr_len),
				.below_base  (cb[(g == 0) ? 0 : g-1]),
				.below_length(cl[(g == 0) ? 0 : g-1]),
				.above_base  (cb[(g == ENTRIES-1) ? g : g+1]),
				.above_length(cl[(g == ENTRIES-1) ? g : g+1]),
				.base        (cb[g]),
				.length      (cl[g])
			);
		end
	endgenerate

	// current scanned cell
	logic [AW-1:0] cur_base, cur_len;
	logic [AW:0]   cur_end, req_end;
	assign cur_base = cb[idx_q];
	assign cur_len  = cl[idx_q];
	assign cur_end  = {1'b0, cur_base} + {1'b0, cur_len};
	assign req_end  = {1'b0, req_base_q} + {1'b0, req_len_q};

	logic [IW-1:0] idx_next;
	logic [CW-1:0] idx_wide_inc;
	assign idx_wide_inc = CW'(idx_q) + CW'(1);
	assign idx_next = (idx_wide_inc >= count_q) ? '0 : idx_wide_inc[IW-1:0];

	logic in_acc, out_acc, scan_last;
	assign in_ready  = (state_q == fpa_pkg::S_IDLE) && !out_valid_q;
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid_q && out_ready;
	assign cfg_ready = 1'b1;
	assign scan_last = (n_q + CW'(1) >= count_q);

	// apply-phase arithmetic on the picked/merge entries
	logic [AW-1:0] pl_b, pl_l, lo_l, up_l;
	logic [AW:0]   left;
	logic [AW+1:0] s_both, s_lo, s_up;
	assign pl_b = cb[pick_q];
	assign pl_l = cl[pick_q];
	assign lo_l = cl[lo_q];
	assign up_l = cl[up_q];
	assign left   = {1'b0, pl_l} - {1'b0, req_len_q};
	assign s_both = {2'b0, lo_l} + {2'b0, req_len_q} + {2'b0, up_l};
	assign s_lo   = {2'b0, lo_l} + {2'b0, req_len_q};
	assign s_up   = {2'b0, up_l} + {2'b0, req_len_q};

	function automatic logic [AW-1:0] sat(input logic [AW+1:0] v);
		return (v > {2'b0, AMAX}) ? AMAX : v[AW-1:0];
	endfunction

	logic carve;
	assign carve = (33'(left) > 33'(min_split_q));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fpa_pkg::S_IDLE:  if (in_acc) state_d = fpa_pkg::S_SCAN;
			fpa_pkg::S_SCAN:  if (count_q == '0 || scan_last) state_d = fpa_pkg::S_APPLY;
			fpa_pkg::S_APPLY: state_d = fpa_pkg::S_SHIFT;
			fpa_pkg::S_SHIFT: if (sh_dir_q == fpa_pkg::SH_HOLD || sh_idx_q == sh_end_q)
				state_d = fpa_pkg::S_DONE;
			fpa_pkg::S_DONE:  state_d = fpa_pkg::S_IDLE;
			default:          state_d = fpa_pkg::S_IDLE;
		endcase
	end

	// row write strobes
	always_comb begin
		wr_en   = '0;
		sh_en   = '0;
		wr_base = req_base_q;
		wr_len  = req_len_q;
		if (state_q == fpa_pkg::S_SHIFT && sh_dir_q != fpa_pkg::SH_HOLD) begin
			sh_en[sh_idx_q] = 1'b1;
		end
		if (state_q == fpa_pkg::S_DONE && mode_q == fpa_pkg::MODE_RELEASE
				&& !has_lo_q && !has_up_q && count_q < CW'(ENTRIES)
				&& req_len_q != '0) begin
			wr_en[pos_q] = 1'b1;
		end
		if (state_q == fpa_pkg::S_APPLY) begin
			priority case (mode_q)
				fpa_pkg::MODE_ALLOC: if (found_q && carve) begin
					wr_en[pick_q] = 1'b1;
					wr_base = pl_b + req_len_q;
					wr_len  = left[AW-1:0];
				end
				fpa_pkg::MODE_RELEASE: if (req_len_q != '0) begin
					if (has_lo_q && has_up_q && lo_q != up_q) begin
						wr_en[lo_q] = 1'b1; wr_base = cb[lo_q]; wr_len = sat(s_both);
					end else if (has_lo_q) begin
						wr_en[lo_q] = 1'b1; wr_base = cb[lo_q]; wr_len = sat(s_lo);
					end else if (has_up_q) begin
						wr_en[up_q] = 1'b1; wr_base = req_base_q; wr_len = sat(s_up);
					end
				end
				fpa_pkg::MODE_APPEND: if (count_q < CW'(ENTRIES)) begin
					wr_en[count_q[IW-1:0]] = 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fpa_pkg::S_IDLE;
			count_q     <= '0;
			rover_q     <= '0;
			policy_q    <= 1'b0;
			min_split_q <= '0;
			out_valid_q <= 1'b0;
			sh_dir_q    <= fpa_pkg::SH_HOLD;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == fpa_pkg::CFG_POLICY) policy_q <= cfg_data[0];
				else min_split_q <= cfg_data;
			end
			if (out_acc) out_valid_q <= 1'b0;

			unique case (state_q)
				fpa_pkg::S_IDLE: if (in_acc) begin
					mode_q     <= in_item.mode;
					req_base_q <= AW'(in_item.block_base);
					req_len_q  <= AW'(in_item.block_length);
					found_q <= 1'b0; has_lo_q <= 1'b0; has_up_q <= 1'b0;
					has_pos_q <= 1'b0;
					n_q <= '0;
					idx_q <= (in_item.mode == fpa_pkg::MODE_ALLOC && !policy_q
						&& CW'(rover_q) < count_q) ? rover_q : '0;
					pick_q <= '0; lo_q <= '0; up_q <= '0;
					pos_q <= count_q[IW-1:0];
					sh_dir_q <= fpa_pkg::SH_HOLD;
				end
				// Visit one cell per cycle.
				fpa_pkg::S_SCAN: begin
					if (count_q != '0) begin
						if (mode_q == fpa_pkg::MODE_ALLOC && cur_len >= req_len_q) begin
							if (!policy_q) begin
								if (!found_q) begin
									found_q <= 1'b1; pick_q <= idx_q; pick_len_q <= cur_len;
								end
							end else if (!found_q || cur_len < pick_len_q) begin
								found_q <= 1'b1; pick_q <= idx_q; pick_len_q <= cur_len;
							end
						end
						if (mode_q == fpa_pkg::MODE_RELEASE) begin
							if (!has_lo_q && cur_end == {1'b0, req_base_q}) begin
								has_lo_q <= 1'b1; lo_q <= idx_q;
							end
							if (!has_up_q && {1'b0, cur_base} == req_end) begin
								has_up_q <= 1'b1; up_q <= idx_q;
							end
							if (!has_pos_q && cur_base > req_base_q) begin
								has_pos_q <= 1'b1; pos_q <= idx_q;
							end
						end
					end
					n_q   <= n_q + CW'(1);
					idx_q <= (policy_q || mode_q != fpa_pkg::MODE_ALLOC)
						? ((CW'(idx_q) + CW'(1) < CW'(ENTRIES)) ? idx_q + IW'(1) : idx_q)
						: idx_next;
				end
				// Commit the in-place update and decide on a row shift.
				fpa_pkg::S_APPLY: begin
					out_q.status         <= fpa_pkg::ST_OK;
					out_q.granted_base   <= '0;
					out_q.granted_length <= '0;
					priority case (mode_q)
						fpa_pkg::MODE_ALLOC: begin
							if (req_len_q == '0 || !found_q) begin
								out_q.status <= fpa_pkg::ST_NOFIT;
							end else begin
								out_q.granted_base <= 16'(pl_b);
								if (carve) begin
									out_q.granted_length <= 16'(req_len_q);
									if (!policy_q) rover_q <= pick_q;
								end else begin
									out_q.granted_length <= 16'(pl_l);
									sh_dir_q <= fpa_pkg::SH_DOWN;
									sh_idx_q <= pick_q;
									sh_end_q <= IW'(count_q - CW'(1));
									count_q  <= count_q - CW'(1);
									if (!policy_q)
										rover_q <= (CW'(pick_q) < count_q - CW'(1)) ? pick_q : '0;
								end
							end
						end
						fpa_pkg::MODE_RELEASE: if (req_len_q != '0) begin
							if (has_lo_q && has_up_q && lo_q != up_q) begin
								sh_dir_q <= fpa_pkg::SH_DOWN;
								sh_idx_q <= up_q;
								sh_end_q <= IW'(count_q - CW'(1));
								count_q  <= count_q - CW'(1);
							end else if (!has_lo_q && !has_up_q) begin
								if (count_q >= CW'(ENTRIES)) begin
									out_q.status <= fpa_pkg::ST_FULL;
								end else if (CW'(pos_q) < count_q) begin
									sh_dir_q <= fpa_pkg::SH_UP;
									sh_idx_q <= count_q[IW-1:0];
									sh_end_q <= pos_q + IW'(1);
								end
							end
						end
						fpa_pkg::MODE_APPEND: begin
							if (count_q >= CW'(ENTRIES)) out_q.status <= fpa_pkg::ST_FULL;
							else count_q <= count_q + CW'(1);
						end
						default: ;
					endcase
				end
				// Move one cell per cycle toward the end of the shift span.
				fpa_pkg::S_SHIFT: begin
					if (sh_dir_q == fpa_pkg::SH_DOWN && sh_idx_q != sh_end_q)
						sh_idx_q <= sh_idx_q + IW'(1);
					else if (sh_dir_q == fpa_pkg::SH_UP && sh_idx_q != sh_end_q)
						sh_idx_q <= sh_idx_q - IW'(1);
				end
				fpa_pkg::S_DONE: begin
					if (wr_en != '0) count_q <= count_q + CW'(1);
					out_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(ENTRIES)) else $error("entry count overflow");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != fpa_pkg::S_IDLE |-> !in_ready) else $error("accept while busy");
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fpa_pkg::S_DONE |=> out_valid) else $error("result lost");

endmodule
